### rtl/gcq_pkg.sv
`timescale 1ns / 1ps

package gcq_pkg;

	localparam int OP_W  = 2;
	localparam int CLS_W = 5;

	localparam logic [CLS_W-1:0] NUM_CLASSES_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER = 2'd0,
		OP_ENQUEUE  = 2'd1,
		OP_DEQUEUE  = 2'd2
	} op_t;

	// command from the stage-1 register to the queue core
	typedef struct packed {
		logic fire;
		logic enq;
		logic deq;
	} core_cmd_t;

	// status of a dequeue evaluated in stage 1
	typedef struct packed {
		logic empty;
	} core_stat_t;

endpackage

### rtl/gcq_item_if.sv
`timescale 1ns / 1ps

interface gcq_item_if #(
	parameter int ID_BITS = 10
);
	logic                          valid;
	logic                          ready;
	logic [gcq_pkg::OP_W-1:0]      operation;
	logic [ID_BITS-1:0]            member_id;
	logic [gcq_pkg::CLS_W-1:0]     class_number;

	modport source (output valid, operation, member_id, class_number, input ready);
	modport sink (input valid, operation, member_id, class_number, output ready);
endinterface

### rtl/gcq_result_if.sv
`timescale 1ns / 1ps

interface gcq_result_if #(
	parameter int ID_BITS = 10
);
	logic               valid;
	logic               ready;
	logic [ID_BITS-1:0] dequeued_id;
	logic               queue_empty;

	modport source (output valid, dequeued_id, queue_empty, input ready);
	modport sink (input valid, dequeued_id, queue_empty, output ready);
endinterface

### rtl/gcq_cfg_if.sv
`timescale 1ns / 1ps

interface gcq_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [gcq_pkg::CLS_W-1:0] num_classes;

	modport source (output valid, num_classes, input ready);
	modport sink (input valid, num_classes, output ready);
endinterface

### rtl/grouped_class_queue.sv
`timescale 1ns / 1ps

// Team queue: members are registered to a class, enqueued behind the last
// queued member of their class (or at the tail), and dequeued from the head.
// An accepted transaction is registered in the input register and processed
// from there, so one transaction per cycle is sustained while results are
// taken; a dequeue held in the input register behind an untaken result holds
// item.ready low. A dequeue result is loaded into the output register when the
// dequeue fires from the input register. The queue pointers are kept in flops
// and the slot links, members and recycled slots in synchronous RAMs whose next
// read address is prefetched from the updated pointers. After reset the member
// directory is cleared entry by entry over its 2**ID_BITS (1024 by default)
// entries, during which item.ready stays low; cfg writes are taken at any time.
module grouped_class_queue #(
	parameter int ID_BITS     = 10,
	parameter int MAX_CLASSES = 16,
	parameter int CAPACITY    = 256
) (
	input logic         clk,
	input logic         arst_n,
	gcq_item_if.sink    item,
	gcq_result_if.source result,
	gcq_cfg_if.sink     cfg
);
	import gcq_pkg::*;

	localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int DW = CW + 1;

	logic [CLS_W-1:0]   num_classes_q;
	logic               clearing_q;
	logic [ID_BITS-1:0] clr_idx_q;

	logic               valid_s1;
	op_t                op_s1;
	logic [ID_BITS-1:0] id_s1;
	logic [CLS_W-1:0]   cls_s1;

	logic               out_valid_q;
	logic [ID_BITS-1:0] out_id_q;
	logic               out_empty_q;

	logic               fire_s1;
	logic               accept;
	logic               reg_ok;
	logic               dir_we;
	logic [ID_BITS-1:0] dir_waddr;
	logic [DW-1:0]      dir_wdata;
	logic [ID_BITS-1:0] dir_raddr;
	logic [DW-1:0]      dir_rd;
	logic [CW-1:0]      cls_wr;
	core_cmd_t          cmd;
	core_stat_t         stat;
	logic [ID_BITS-1:0] deq_id;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NUM_CLASSES_RESET;
		end else if (cfg.valid) begin
			num_classes_q <= cfg.num_classes;
		end
	end

	assign fire_s1    = valid_s1 && ((op_s1 != OP_DEQUEUE) || !out_valid_q || result.ready);
	assign item.ready = !clearing_q && (!valid_s1 || fire_s1);
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(item.operation);
			id_s1  <= item.member_id;
			cls_s1 <= item.class_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign cls_wr = CW'(cls_s1 - 5'd1);

	always_comb begin
		cmd    = '0;
		reg_ok = 1'b0;
		cmd.fire = fire_s1;
		unique case (op_s1)
			OP_REGISTER: begin
				reg_ok = (cls_s1 != '0) && (cls_s1 <= num_classes_q) &&
					(int'(cls_s1) <= MAX_CLASSES) && !dir_rd[DW-1];
			end
			OP_ENQUEUE: begin
				cmd.enq = dir_rd[DW-1];
			end
			OP_DEQUEUE: begin
				cmd.deq = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (clearing_q) begin
			dir_we    = 1'b1;
			dir_waddr = clr_idx_q;
			dir_wdata = '0;
		end else begin
			dir_we    = fire_s1 && reg_ok;
			dir_waddr = id_s1;
			dir_wdata = {1'b1, cls_wr};
		end
	end

	assign dir_raddr = item.ready ? item.member_id : id_s1;

	gcq_ram #(.DATA_W(DW), .DEPTH(2 ** ID_BITS), .ADDR_W(ID_BITS)) u_dir (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr (dir_raddr),
		.rdata (dir_rd)
	);

	gcq_core #(
		.ID_BITS    (ID_BITS),
		.MAX_CLASSES(MAX_CLASSES),
		.CAPACITY   (CAPACITY),
		.CW         (CW)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.id     (id_s1),
		.cls_idx(dir_rd[CW-1:0]),
		.deq_id (deq_id),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fire && cmd.deq) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire && cmd.deq) begin
			out_id_q    <= deq_id;
			out_empty_q <= stat.empty;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.dequeued_id = out_id_q;
	assign result.queue_empty = out_empty_q;

endmodule

### rtl/gcq_ram.sv
`timescale 1ns / 1ps

module gcq_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] wd_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
		wd_q <= wdata;
	end

	// write in the same cycle as the read returns the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= we && (waddr == raddr);
		end
	end

	assign rdata = hit_q ? wd_q : rd_q;

endmodule

### rtl/gcq_core.sv
`timescale 1ns / 1ps

module gcq_core #(
	parameter int ID_BITS     = 10,
	parameter int MAX_CLASSES = 16,
	parameter int CAPACITY    = 256,
	parameter int CW          = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gcq_pkg::core_cmd_t    cmd,
	input  logic [ID_BITS-1:0]    id,
	input  logic [CW-1:0]         cls_idx,
	output logic [ID_BITS-1:0]    deq_id,
	output gcq_pkg::core_stat_t   stat
);
	import gcq_pkg::*;

	localparam int SW  = $clog2(CAPACITY);
	localparam int NW  = $clog2(CAPACITY + 1);
	localparam int OCW = $clog2(MAX_CLASSES + 1);
	localparam int IW  = CW + 2;

	logic [SW-1:0]  class_head_q [MAX_CLASSES];
	logic [SW-1:0]  class_tail_q [MAX_CLASSES];
	logic [CW-1:0]  ring_q [MAX_CLASSES];
	logic [MAX_CLASSES-1:0] queued_q;
	logic [CW-1:0]  order_head_q;
	logic [OCW-1:0] order_count_q;
	logic [NW-1:0]  occ_q;
	logic [NW-1:0]  fresh_q;
	logic [SW-1:0]  rec_rd_q;
	logic [SW-1:0]  rec_wr_q;

	logic [SW-1:0]  class_head_d [MAX_CLASSES];
	logic [SW-1:0]  class_tail_d [MAX_CLASSES];
	logic [CW-1:0]  ring_d [MAX_CLASSES];
	logic [MAX_CLASSES-1:0] queued_d;
	logic [CW-1:0]  order_head_d;
	logic [OCW-1:0] order_count_d;
	logic [NW-1:0]  occ_d;
	logic [NW-1:0]  fresh_d;
	logic [SW-1:0]  rec_rd_d;
	logic [SW-1:0]  rec_wr_d;

	logic              mem_we;
	logic [SW-1:0]     mem_waddr;
	logic              nxt_we;
	logic [SW-1:0]     nxt_waddr;
	logic [SW-1:0]     nxt_wdata;
	logic              rec_we;
	logic [SW-1:0]     slot_raddr;
	logic [ID_BITS-1:0] member_rd;
	logic [SW-1:0]     next_rd;
	logic [SW-1:0]     rec_rd;

	logic [CW-1:0]     c_deq;
	logic [SW-1:0]     s_deq;
	logic [SW-1:0]     s_new;
	logic [IW-1:0]     ring_sum;
	logic [CW-1:0]     ring_idx;
	logic              empty;

	assign c_deq = ring_q[order_head_q];
	assign s_deq = class_head_q[c_deq];
	assign empty = (order_count_q == '0);
	assign s_new = (fresh_q < NW'(CAPACITY)) ? fresh_q[SW-1:0] : rec_rd;

	always_comb begin
		ring_sum = IW'(order_head_q) + IW'(order_count_q);
		if (ring_sum >= IW'(MAX_CLASSES)) begin
			ring_sum = ring_sum - IW'(MAX_CLASSES);
		end
		ring_idx = ring_sum[CW-1:0];
	end

	always_comb begin
		class_head_d  = class_head_q;
		class_tail_d  = class_tail_q;
		ring_d        = ring_q;
		queued_d      = queued_q;
		order_head_d  = order_head_q;
		order_count_d = order_count_q;
		occ_d         = occ_q;
		fresh_d       = fresh_q;
		rec_rd_d      = rec_rd_q;
		rec_wr_d      = rec_wr_q;
		mem_we        = 1'b0;
		mem_waddr     = s_new;
		nxt_we        = 1'b0;
		nxt_waddr     = class_tail_q[cls_idx];
		nxt_wdata     = s_new;
		rec_we        = 1'b0;

		if (cmd.fire && cmd.deq && !empty) begin
			if (s_deq == class_tail_q[c_deq]) begin
				queued_d[c_deq] = 1'b0;
				order_head_d    = (order_head_q == CW'(MAX_CLASSES - 1)) ? '0 :
					order_head_q + 1'b1;
				order_count_d   = order_count_q - 1'b1;
			end else begin
				class_head_d[c_deq] = next_rd;
			end
			rec_we   = 1'b1;
			rec_wr_d = (rec_wr_q == SW'(CAPACITY - 1)) ? '0 : rec_wr_q + 1'b1;
			occ_d    = occ_q - 1'b1;
		end

		if (cmd.fire && cmd.enq && (occ_q < NW'(CAPACITY))) begin
			if (fresh_q < NW'(CAPACITY)) begin
				fresh_d = fresh_q + 1'b1;
			end else begin
				rec_rd_d = (rec_rd_q == SW'(CAPACITY - 1)) ? '0 : rec_rd_q + 1'b1;
			end
			mem_we = 1'b1;
			occ_d  = occ_q + 1'b1;
			if (queued_q[cls_idx]) begin
				nxt_we                = 1'b1;
				class_tail_d[cls_idx] = s_new;
			end else begin
				queued_d[cls_idx]     = 1'b1;
				class_head_d[cls_idx] = s_new;
				class_tail_d[cls_idx] = s_new;
				ring_d[ring_idx]      = cls_idx;
				order_count_d         = order_count_q + 1'b1;
			end
		end

		// prefetch the slot that will be at the head after this cycle
		slot_raddr = class_head_d[ring_d[order_head_d]];
	end

	always_ff @(posedge clk) begin
		class_head_q <= class_head_d;
		class_tail_q <= class_tail_d;
		ring_q       <= ring_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q      <= '0;
			order_head_q  <= '0;
			order_count_q <= '0;
			occ_q         <= '0;
			fresh_q       <= '0;
			rec_rd_q      <= '0;
			rec_wr_q      <= '0;
		end else begin
			queued_q      <= queued_d;
			order_head_q  <= order_head_d;
			order_count_q <= order_count_d;
			occ_q         <= occ_d;
			fresh_q       <= fresh_d;
			rec_rd_q      <= rec_rd_d;
			rec_wr_q      <= rec_wr_d;
		end
	end

	gcq_ram #(.DATA_W(ID_BITS), .DEPTH(CAPACITY), .ADDR_W(SW)) u_member (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (id),
		.raddr (slot_raddr),
		.rdata (member_rd)
	);

	gcq_ram #(.DATA_W(SW), .DEPTH(CAPACITY), .ADDR_W(SW)) u_next (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (slot_raddr),
		.rdata (next_rd)
	);

	// recycled slots, in the order they were freed
	gcq_ram #(.DATA_W(SW), .DEPTH(CAPACITY), .ADDR_W(SW)) u_recycle (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (rec_we),
		.waddr (rec_wr_q),
		.wdata (s_deq),
		.raddr (rec_rd_d),
		.rdata (rec_rd)
	);

	assign deq_id     = empty ? '0 : member_rd;
	assign stat.empty = empty;

endmodule

### rtl/gcq_checker.sv
`timescale 1ns / 1ps

module gcq_checker #(
	parameter int ID_BITS = 10
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_ready,
	input logic [gcq_pkg::OP_W-1:0] item_operation,
	input logic                     result_valid,
	input logic                     result_ready,
	input logic [ID_BITS-1:0]       result_dequeued_id,
	input logic                     result_queue_empty
);
	import gcq_pkg::*;

	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// an empty dequeue reports id zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_queue_empty |-> result_dequeued_id == '0)
		else $error("empty dequeue with nonzero id");

	// a fresh result comes from an accepted dequeue transaction
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(item_valid && item_ready && (item_operation == OP_DEQUEUE), 2))
		else $error("result without dequeue");

endmodule

bind grouped_class_queue gcq_checker #(.ID_BITS(ID_BITS)) u_gcq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_operation    (item.operation),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_dequeued_id(result.dequeued_id),
	.result_queue_empty(result.queue_empty)
);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gcq_pkg::*;

	localparam int ID_W        = 10;
	localparam int SLOTS       = 256;
	localparam int TOP_CLASS   = 16;
	localparam int IDLE_MAX    = 17;
	localparam int SETTLE      = 4;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CLS_W-1:0] cls;
	} member_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            empty;
	} head_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gcq_item_if   item_ch ();
	gcq_result_if result_ch ();
	gcq_cfg_if    cfg_ch ();

	grouped_class_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// predicted block state: the whole queue as one line, class members contiguous
	bit               bound [1 << ID_W];
	logic [CLS_W-1:0] bound_cls [1 << ID_W];
	member_t          team_line [$];
	logic [CLS_W-1:0] class_limit = NUM_CLASSES_RESET;
	logic [ID_W-1:0]  known_ids [$];
	head_t            due_dequeues [$];

	int  fail_count = 0;
	bit  steady = 1'b0;

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endfunction

	function automatic void team_queue_step(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [CLS_W-1:0] cls);
		int last;
		member_t m;
		head_t h;
		case (op)
			OP_REGISTER: begin
				if (cls >= 1 && cls <= class_limit && cls <= TOP_CLASS && !bound[id]) begin
					bound[id] = 1'b1;
					bound_cls[id] = cls;
					known_ids.insert(known_ids.size(), id);
				end
			end
			OP_ENQUEUE: begin
				if (bound[id] && team_line.size() < SLOTS) begin
					m.id = id;
					m.cls = bound_cls[id];
					last = -1;
					foreach (team_line[i])
						if (team_line[i].cls == m.cls)
							last = i;
					if (last < 0 || last == team_line.size() - 1)
						team_line.insert(team_line.size(), m);
					else
						team_line.insert(last + 1, m);
				end
			end
			OP_DEQUEUE: begin
				if (team_line.size() == 0) begin
					h.id = '0;
					h.empty = 1'b1;
				end else begin
					m = team_line[0];
					team_line.delete(0);
					h.id = m.id;
					h.empty = 1'b0;
				end
				due_dequeues.insert(due_dequeues.size(), h);
			end
			default: ;
		endcase
	endfunction

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, IDLE_MAX);
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.member_id <= id;
		item_ch.class_number <= cls;
		do @(posedge clk); while (!item_ch.ready);
		team_queue_step(op, id, cls);
	endtask

	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (due_dequeues.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_class_limit(logic [CLS_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.num_classes <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		class_limit = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: random stall per transaction, check against the oldest prediction
	initial begin
		int stall;
		head_t want;
		result_ch.ready = 1'b0;
		forever begin
			stall = draw_gap();
			repeat (stall) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (due_dequeues.size() == 0) begin
				note_failure($sformatf("unexpected result id=%0d empty=%0b",
					result_ch.dequeued_id, result_ch.queue_empty));
			end else begin
				want = due_dequeues[0];
				due_dequeues.delete(0);
				if (result_ch.dequeued_id !== want.id)
					note_failure($sformatf("dequeued_id expected %0d got %0d",
						want.id, result_ch.dequeued_id));
				if (result_ch.queue_empty !== want.empty)
					note_failure($sformatf("queue_empty expected %0b got %0b",
						want.empty, result_ch.queue_empty));
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	task automatic test_directed();
		steady = 1'b0;
		send_item(OP_DEQUEUE, 10'd0, 5'd0);
		send_item(OP_REGISTER, 10'd0, 5'd1);
		send_item(OP_REGISTER, 10'd1023, 5'd16);
		send_item(OP_REGISTER, 10'd5, 5'd0);
		send_item(OP_REGISTER, 10'd0, 5'd16);
		send_item(OP_REGISTER, 10'd682, 5'd1);
		send_item(OP_REGISTER, 10'd341, 5'd16);
		send_item(OP_ENQUEUE, 10'd5, 5'd0);
		send_item(OP_ENQUEUE, 10'd0, 5'd31);
		send_item(OP_ENQUEUE, 10'd1023, 5'd0);
		send_item(OP_ENQUEUE, 10'd682, 5'd0);
		send_item(OP_ENQUEUE, 10'd341, 5'd0);
		send_item(OP_UNUSED, 10'd1023, 5'd16);
		send_item(OP_ENQUEUE, 10'd0, 5'd0);
		repeat (6) send_item(OP_DEQUEUE, 10'd0, 5'd0);
	endtask

	task automatic test_class_limit();
		write_class_limit(5'd1);
		send_item(OP_REGISTER, 10'd9, 5'd2);
		send_item(OP_REGISTER, 10'd10, 5'd1);
		send_item(OP_ENQUEUE, 10'd9, 5'd0);
		send_item(OP_ENQUEUE, 10'd10, 5'd0);
		send_item(OP_DEQUEUE, 10'd0, 5'd0);
		send_item(OP_DEQUEUE, 10'd0, 5'd0);
		write_class_limit(5'd16);
	endtask

	task automatic test_full_store();
		steady = 1'b1;
		for (int i = 0; i < SLOTS + 2; i++) begin
			if (i == SLOTS / 2)
				steady = 1'b0;
			send_item(OP_ENQUEUE, known_ids[$urandom_range(0, known_ids.size() - 1)], 5'd0);
		end
		for (int i = 0; i < SLOTS / 2; i++) begin
			if (i == SLOTS / 4)
				steady = 1'b1;
			send_item(OP_DEQUEUE, 10'd0, 5'd0);
		end
		steady = 1'b0;
	endtask

	task automatic test_random();
		logic [CLS_W-1:0] limits [5];
		logic [ID_W-1:0] id;
		int pick;
		limits = '{5'd16, 5'd1, 5'd5, 5'd11, 5'd16};
		foreach (limits[p]) begin
			write_class_limit(limits[p]);
			for (int n = 0; n < 28; n++) begin
				if (n % 40 == 0)
					steady = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
				if (pick < 20) begin
					send_item(OP_REGISTER, id, CLS_W'($urandom_range(0, TOP_CLASS)));
				end else if (pick < 62) begin
					if (known_ids.size() > 0 && $urandom_range(0, 9) < 8)
						id = known_ids[$urandom_range(0, known_ids.size() - 1)];
					send_item(OP_ENQUEUE, id, CLS_W'($urandom_range(0, TOP_CLASS)));
				end else if (pick < 96) begin
					send_item(OP_DEQUEUE, id, CLS_W'($urandom_range(0, TOP_CLASS)));
				end else begin
					send_item(OP_UNUSED, id, CLS_W'($urandom_range(0, TOP_CLASS)));
				end
			end
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.operation = OP_REGISTER;
		item_ch.member_id = '0;
		item_ch.class_number = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.num_classes = NUM_CLASSES_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_class_limit();
		test_full_store();
		test_random();

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && due_dequeues.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
rtl/gcq_pkg.sv
rtl/gcq_item_if.sv
rtl/gcq_result_if.sv
rtl/gcq_cfg_if.sv
rtl/gcq_ram.sv
rtl/gcq_core.sv
rtl/grouped_class_queue.sv
rtl/gcq_checker.sv
verif/tb_top.sv
